>>> design/crp_pkg.sv
// ----------------------------------------------------------------------------
// crp_pkg
// Request codes and the result record shared by the clock replacer modules.
// ----------------------------------------------------------------------------
package crp_pkg;

    localparam logic [1:0] FUNC_VICTIM = 2'd0;
    localparam logic [1:0] FUNC_PIN    = 2'd1;
    localparam logic [1:0] FUNC_UNPIN  = 2'd2;

    localparam int FUNC_W   = 2;
    localparam int FRAME_W  = 7;
    localparam int VICTIM_W = 6;
    localparam int COUNT_W  = 7;

    // one memory word per frame
    typedef struct packed {
        logic evictable;
        logic referenced;
    } slot_t;

    // found travels on tuser, frame and count on tdata
    typedef struct packed {
        logic [COUNT_W-1:0]  evictable_count;
        logic [VICTIM_W-1:0] victim_frame;
        logic                found;
    } res_t;

endpackage

>>> design/clock_page_replacer.sv
// ----------------------------------------------------------------------------
// clock_page_replacer
// Clock (second-chance) replacer over NUM_FRAMES frames.
// ----------------------------------------------------------------------------
// Requests arrive on s_tvalid/s_tready with the code on s_tuser and the frame
// on s_tdata, one beat each; every request gives exactly one result beat on
// m_tvalid/m_tready, found on m_tuser and frame and count on m_tdata.
// Per-frame evictable and reference bits live in a one-port-read,
// one-port-write RAM with a registered read; hand and evictable count sit
// in flops.
// Pin and unpin: RAM read, then modify and write back.
// Out-of-range frames and unknown codes: no RAM access.
// Victim: the sweep visits the frames from the hand up to and including
// the victim (up to NUM_FRAMES + 1), one frame per cycle set by
// the single RAM read port. Victim with nothing evictable: no RAM access.
// One request is in flight at a time; the next is taken once its result
// has moved into the output register.
// After reset the RAM is cleared frame by frame with s_tready low.
// A stalled m_tready holds the result beat steady and, once the output
// register is full, holds the next result inside the block.
// ----------------------------------------------------------------------------
module clock_page_replacer
    import crp_pkg::*;
#(
    parameter int NUM_FRAMES = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // frame[6:0], zero[7]
    input  logic [1:0]  s_tuser,   // func[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // victim_frame[5:0], evictable_count[12:6],
                                   // zero[15:13]
    output logic        m_tuser    // found[0]
);

    localparam int AW = (NUM_FRAMES > 2) ? $clog2(NUM_FRAMES) : 1;
    localparam int LW = $clog2(NUM_FRAMES + 1);

    logic          res_valid, res_ready;
    res_t          res;
    logic          wr_en;
    logic [AW-1:0] wr_addr, rd_addr;
    slot_t         wr_data, rd_data;
    logic          m_tvalid_reg;
    res_t          m_res_reg;

    assign res_ready = !m_tvalid_reg || m_tready;

    crp_sweep_ctrl #(
        .NUM_FRAMES (NUM_FRAMES),
        .AW         (AW),
        .LW         (LW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .req_func  (s_tuser),
        .req_frame (s_tdata[FRAME_W-1:0]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    crp_frame_ram #(
        .DEPTH (NUM_FRAMES),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            m_tvalid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, m_res_reg.evictable_count, m_res_reg.victim_frame};
    assign m_tuser  = m_res_reg.found;

endmodule

>>> design/crp_frame_ram.sv
// ----------------------------------------------------------------------------
// crp_frame_ram
// Frame state memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module crp_frame_ram
    import crp_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  slot_t         wr_data,
    input  logic [AW-1:0] rd_addr,
    output slot_t         rd_data
);

    slot_t mem [DEPTH];
    slot_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> design/crp_sweep_ctrl.sv
// ----------------------------------------------------------------------------
// crp_sweep_ctrl
// Request sequencer: clearing pass, pin/unpin read-modify-write and the
// one-frame-per-cycle victim sweep from the hand.
// ----------------------------------------------------------------------------
module crp_sweep_ctrl
    import crp_pkg::*;
#(
    parameter int NUM_FRAMES = 64,
    parameter int AW         = 6,
    parameter int LW         = 7
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  logic [FUNC_W-1:0]  req_func,
    input  logic [FRAME_W-1:0] req_frame,
    output logic               res_valid,
    input  logic               res_ready,
    output res_t               res,
    output logic               wr_en,
    output logic [AW-1:0]      wr_addr,
    output slot_t              wr_data,
    output logic [AW-1:0]      rd_addr,
    input  slot_t              rd_data
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RMW,
        ST_SWEEP,
        ST_RESULT
    } state_t;

    localparam logic [AW-1:0] LAST = AW'(NUM_FRAMES - 1);

    state_t            state_reg, state_next;
    logic [AW-1:0]     hand_reg, hand_next;
    logic [AW-1:0]     ptr_reg, ptr_next;
    logic [LW-1:0]     live_reg, live_next;
    logic [FUNC_W-1:0] func_reg, func_next;
    res_t              res_reg, res_next;
    logic [AW-1:0]     ptr_inc;
    logic              in_range;

    assign ptr_inc  = (ptr_reg == LAST) ? '0 : ptr_reg + 1'b1;
    assign in_range = int'(req_frame) < NUM_FRAMES;
    assign req_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        hand_next  = hand_reg;
        ptr_next   = ptr_reg;
        live_next  = live_reg;
        func_next  = func_reg;
        res_next   = res_reg;
        rd_addr    = ptr_reg;
        wr_en      = 1'b0;
        wr_addr    = ptr_reg;
        wr_data    = '0;
        res_valid  = 1'b0;
        res        = res_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                wr_en    = 1'b1;
                ptr_next = ptr_inc;
                if (ptr_reg == LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    func_next = req_func;
                    res_next  = '{evictable_count: COUNT_W'(live_reg),
                                  victim_frame: '0, found: 1'b0};
                    if ((req_func == FUNC_PIN || req_func == FUNC_UNPIN) && in_range)
                    begin
                        ptr_next   = AW'(req_frame);
                        rd_addr    = AW'(req_frame);
                        state_next = ST_RMW;
                    end
                    else if (req_func == FUNC_VICTIM && live_reg != '0)
                    begin
                        ptr_next   = hand_reg;
                        rd_addr    = hand_reg;
                        state_next = ST_SWEEP;
                    end
                    else
                    begin
                        state_next = ST_RESULT;
                    end
                end
            end
            ST_RMW:
            begin
                res_valid = 1'b1;
                if (func_reg == FUNC_PIN)
                begin
                    wr_data   = '0;
                    live_next = live_reg - LW'(rd_data.evictable);
                end
                else
                begin
                    wr_data   = '{evictable: 1'b1, referenced: 1'b1};
                    live_next = live_reg + LW'(!rd_data.evictable);
                    if (rd_data.evictable)
                    begin
                        wr_data = rd_data;
                    end
                end
                res = '{evictable_count: COUNT_W'(live_next),
                        victim_frame: '0, found: 1'b0};
                if (res_ready)
                begin
                    wr_en      = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    live_next = live_reg;
                end
            end
            ST_SWEEP:
            begin
                if (rd_data.evictable && !rd_data.referenced)
                begin
                    res_valid = 1'b1;
                    res = '{evictable_count: COUNT_W'(live_reg - 1'b1),
                            victim_frame: VICTIM_W'(ptr_reg), found: 1'b1};
                    if (res_ready)
                    begin
                        wr_en      = 1'b1;
                        wr_data    = '0;
                        live_next  = live_reg - 1'b1;
                        hand_next  = ptr_inc;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    // second chance: drop the reference bit and move on
                    wr_en    = rd_data.evictable;
                    wr_data  = '{evictable: 1'b1, referenced: 1'b0};
                    ptr_next = ptr_inc;
                    rd_addr  = ptr_inc;
                end
            end
            ST_RESULT:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            hand_reg  <= '0;
            ptr_reg   <= '0;
            live_reg  <= '0;
            func_reg  <= '0;
            res_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            hand_reg  <= hand_next;
            ptr_reg   <= ptr_next;
            live_reg  <= live_next;
            func_reg  <= func_next;
            res_reg   <= res_next;
        end
    end

endmodule

>>> design/crp_checker.sv
// ----------------------------------------------------------------------------
// crp_checker
// Port-level checks on the clock replacer, bound to the top level.
// ----------------------------------------------------------------------------
module crp_checker
    import crp_pkg::*;
#(
    parameter int NUM_FRAMES = 64
)
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tuser
);

    a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !m_tvalid && !s_tready)
        else $error("beats offered during reset");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result beat changed");

    a_no_victim: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata[5:0] == 6'd0)
        else $error("victim frame set without found");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> int'(m_tdata[12:6]) <= NUM_FRAMES)
        else $error("evictable count above frame count");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[15:13] == 3'b000)
        else $error("result padding not zero");

endmodule

bind clock_page_replacer crp_checker #(.NUM_FRAMES(NUM_FRAMES)) u_crp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

>>> tb/clock_page_replacer_checker.sv
// ----------------------------------------------------------------------------
// clock_page_replacer_checker
// Watches both streams of the clock replacer and checks every reply against
// its own second-chance sweep over the frame bits, hand and evictable count.
// Replies are matched in order; the count of mismatches and the number of
// replies still owed are handed to the testbench top.
// ----------------------------------------------------------------------------
module clock_page_replacer_checker
    import crp_pkg::*;
#(
    parameter int NUM_FRAMES = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // frame[6:0], zero[7]
    input  logic [1:0]  s_tuser,   // func[1:0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // victim_frame[5:0], evictable_count[12:6],
                                   // zero[15:13]
    input  logic        m_tuser,   // found[0]
    output int          mismatches,
    output int          replies_owed
);

    bit [NUM_FRAMES-1:0] evictable;
    bit [NUM_FRAMES-1:0] referenced;
    int                  hand;
    int                  live_frames;
    res_t                replies_due[$];

    initial
    begin
        evictable    = '0;
        referenced   = '0;
        hand         = 0;
        live_frames  = 0;
        mismatches   = 0;
        replies_owed = 0;
    end

    task automatic sweep_and_update(input logic [FUNC_W-1:0] func,
                                    input logic [FRAME_W-1:0] frame);
        res_t r;
        int   p;
        int   n;
        r = '0;
        case (func)
            FUNC_VICTIM:
            begin
                if (live_frames != 0)
                begin
                    p = hand;
                    for (n = 0; n < 2 * NUM_FRAMES && !r.found; n++)
                    begin
                        if (evictable[p] && referenced[p])
                            referenced[p] = 1'b0;
                        else if (evictable[p])
                        begin
                            evictable[p]   = 1'b0;
                            live_frames    = live_frames - 1;
                            r.found        = 1'b1;
                            r.victim_frame = VICTIM_W'(p);
                            hand           = (p + 1 >= NUM_FRAMES) ? 0 : p + 1;
                        end
                        if (!r.found)
                            p = (p + 1 >= NUM_FRAMES) ? 0 : p + 1;
                    end
                end
            end
            FUNC_PIN:
            begin
                if (int'(frame) < NUM_FRAMES)
                begin
                    if (evictable[frame])
                        live_frames = live_frames - 1;
                    evictable[frame]  = 1'b0;
                    referenced[frame] = 1'b0;
                end
            end
            FUNC_UNPIN:
            begin
                if (int'(frame) < NUM_FRAMES && !evictable[frame])
                begin
                    evictable[frame]  = 1'b1;
                    referenced[frame] = 1'b1;
                    live_frames       = live_frames + 1;
                end
            end
            default:
            begin
            end
        endcase
        r.evictable_count = COUNT_W'(live_frames);
        replies_due.push_back(r);
    endtask

    always @(posedge clk)
    begin
        res_t want;
        res_t got;
        if (rst_n)
        begin
            // reply first, so a beat never meets the request taken at the same edge
            if (m_tvalid && m_tready)
            begin
                got.found           = m_tuser;
                got.victim_frame    = m_tdata[5:0];
                got.evictable_count = m_tdata[12:6];
                if (replies_due.size() == 0)
                begin
                    $error("reply beat with none outstanding: %h", m_tdata);
                    mismatches = mismatches + 1;
                end
                else
                begin
                    want = replies_due.pop_front();
                    if (got.found !== want.found)
                    begin
                        $error("found: expected %0d, got %0d", want.found, got.found);
                        mismatches = mismatches + 1;
                    end
                    if (got.victim_frame !== want.victim_frame)
                    begin
                        $error("victim_frame: expected %0d, got %0d",
                               want.victim_frame, got.victim_frame);
                        mismatches = mismatches + 1;
                    end
                    if (got.evictable_count !== want.evictable_count)
                    begin
                        $error("evictable_count: expected %0d, got %0d",
                               want.evictable_count, got.evictable_count);
                        mismatches = mismatches + 1;
                    end
                end
            end
            if (s_tvalid && s_tready)
                sweep_and_update(s_tuser, s_tdata[6:0]);
            replies_owed = replies_due.size();
        end
    end

endmodule

>>> tb/clock_page_replacer_tb.sv
// ----------------------------------------------------------------------------
// clock_page_replacer_tb
// Stimulus and verdict for the clock replacer.
// A directed run covers empty and wrapping sweeps, repeated unpins, pins of
// free and evictable frames, out-of-range frames and the unused request
// code; random phases then mix pins, unpins and victim requests with random
// gaps on both streams and one long hold-off on the reply side.
// ----------------------------------------------------------------------------
module clock_page_replacer_tb;
    import crp_pkg::*;

    localparam int          NUM_FRAMES  = 64;
    localparam logic [1:0]  FUNC_RSVD   = 2'd3;
    localparam int          HOLD_CYCLES = 400;
    localparam int          IDLE_LIMIT  = 5000;
    localparam int          TAIL_CYCLES = 2 * NUM_FRAMES + 20;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;     // frame[6:0], zero[7]
    logic [1:0]  s_tuser;     // func[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;     // victim_frame[5:0], evictable_count[12:6], zero[15:13]
    logic        m_tuser;     // found[0]

    int mismatches;
    int replies_owed;
    int idle_cycles;
    bit hold_req;
    bit rx_steady;
    bit tx_steady;

    clock_page_replacer #(.NUM_FRAMES(NUM_FRAMES)) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    clock_page_replacer_checker #(.NUM_FRAMES(NUM_FRAMES)) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .mismatches   (mismatches),
        .replies_owed (replies_owed)
    );

    initial
        clk = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int gap_length(bit steady);
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // stalls no longer than HOLD_CYCLES, so the idle limit has ample margin
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // reply side
    initial
    begin
        int run;
        int stall;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            run   = $urandom_range(1, 20);
            stall = gap_length(rx_steady);
            m_tready <= 1'b1;
            repeat (run) @(posedge clk);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    task automatic issue_request(input logic [1:0] func, input logic [6:0] frame);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, frame};
        s_tuser  <= func;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        gap = gap_length(tx_steady);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic random_requests(input int count, input int unpin_pct,
                                   input int pin_pct, input int victim_pct);
        int          i;
        int          r;
        logic [1:0]  func;
        logic [6:0]  frame;
        for (i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < unpin_pct)
                func = FUNC_UNPIN;
            else if (r < unpin_pct + pin_pct)
                func = FUNC_PIN;
            else if (r < unpin_pct + pin_pct + victim_pct)
                func = FUNC_VICTIM;
            else
                func = FUNC_RSVD;
            if ($urandom_range(0, 99) < 92)
                frame = 7'($urandom_range(0, NUM_FRAMES - 1));
            else
                frame = 7'($urandom_range(NUM_FRAMES, 127));
            issue_request(func, frame);
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        hold_req  = 1'b0;
        rx_steady = 1'b0;
        tx_steady = 1'b0;
        idle_cycles = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed
        issue_request(FUNC_VICTIM, 7'd0);      // nothing evictable
        issue_request(FUNC_RSVD,   7'd127);
        issue_request(FUNC_UNPIN,  7'd0);
        issue_request(FUNC_UNPIN,  7'd63);
        issue_request(FUNC_UNPIN,  7'd63);     // already evictable
        issue_request(FUNC_UNPIN,  7'd64);     // out of range
        issue_request(FUNC_PIN,    7'd127);
        issue_request(FUNC_VICTIM, 7'd0);      // full turn of second chances
        issue_request(FUNC_VICTIM, 7'd0);      // hand wraps to 0
        issue_request(FUNC_PIN,    7'd5);      // pin of a pinned frame
        issue_request(FUNC_UNPIN,  7'd5);
        issue_request(FUNC_PIN,    7'd5);      // pin of an evictable frame
        issue_request(FUNC_UNPIN,  7'd10);
        issue_request(FUNC_UNPIN,  7'd11);
        issue_request(FUNC_VICTIM, 7'd0);
        issue_request(FUNC_UNPIN,  7'd10);
        issue_request(FUNC_VICTIM, 7'd0);
        issue_request(FUNC_VICTIM, 7'd0);
        issue_request(FUNC_UNPIN,  7'd127);
        issue_request(FUNC_RSVD,   7'd0);
        issue_request(FUNC_PIN,    7'd0);
        issue_request(FUNC_VICTIM, 7'd127);

        // balanced, with the long reply hold-off part way through
        random_requests(150, 40, 20, 35);
        hold_req = 1'b1;
        random_requests(300, 40, 20, 35);

        // fill towards every frame evictable
        random_requests(350, 82, 4, 10);

        // victim-heavy, no idling on either side
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        random_requests(250, 40, 10, 46);
        tx_steady = 1'b0;
        rx_steady = 1'b0;

        random_requests(250, 45, 20, 30);
        s_tvalid <= 1'b0;
        @(posedge clk);

        wait (replies_owed == 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && replies_owed == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
